### src/tpst_pkg.sv
// Shared types, widths and helpers for the two-point similarity transform core.
// No dependencies; the design modules refer to it by scoped names.
package tpst_pkg;

  localparam int unsigned DEN_W = 66;   // |a|^2, unsigned
  localparam int unsigned PRD_W = 67;   // dot and cross, signed
  localparam int unsigned NUM_W = 104;  // numerators, signed
  localparam int unsigned MAG_W = 104;  // rounded magnitudes
  localparam int unsigned Q_W   = 32;
  localparam int unsigned LANES = 4;

  localparam int unsigned LANE_A = 0;
  localparam int unsigned LANE_B = 1;
  localparam int unsigned LANE_X = 2;
  localparam int unsigned LANE_Y = 3;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_DEGEN = 2'd1;
  localparam logic [1:0] STATUS_SAT   = 2'd2;

  typedef struct packed {
    logic signed [31:0] src1_x;
    logic signed [31:0] src1_y;
    logic signed [31:0] src2_x;
    logic signed [31:0] src2_y;
    logic signed [31:0] dst1_x;
    logic signed [31:0] dst1_y;
    logic signed [31:0] dst2_x;
    logic signed [31:0] dst2_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] coef_a;
    logic signed [31:0] coef_b;
    logic signed [31:0] coef_c;
    logic signed [31:0] coef_d;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic        [1:0]  status;
  } out_item_t;

  // front end result: segment sums plus the first points
  typedef struct packed {
    logic        [DEN_W-1:0] den;
    logic signed [PRD_W-1:0] dot;
    logic signed [PRD_W-1:0] crs;
    logic signed [31:0]      x1;
    logic signed [32:0]      y1;
    logic signed [31:0]      u1;
    logic signed [31:0]      v1;
  } fr_t;

  // flags that travel beside the divider lanes
  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic [LANES-1:0] neg;
    logic [LANES-1:0] sat;
    logic             neg_c;
    logic             sat_c;
    logic             degen;
  } dvf_t;

  typedef struct packed {
    logic [LANES-1:0][MAG_W-1:0] mag;
    dvf_t                        fl;
  } dv_t;

  // |num| + floor(den/2): rounds to nearest, ties away from zero
  function automatic logic [MAG_W-1:0] mag_round(logic signed [NUM_W-1:0] num,
                                                 logic [DEN_W-1:0] den);
    logic [NUM_W-1:0] a;
    a = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    return MAG_W'(a) + MAG_W'(den >> 1);
  endfunction

  // quotient beyond the signed 32-bit bound for this sign
  function automatic logic over(logic [MAG_W-1:0] mag, logic [DEN_W-1:0] den,
                                logic neg);
    logic [MAG_W-1:0] lim;
    lim = (MAG_W'(den) << 31) + (neg ? MAG_W'(den) : MAG_W'(0));
    return mag >= lim;
  endfunction

endpackage

### src/tpst_stream_if.sv
// Valid/ready stream channel carrying one payload item per transfer.
// Payload type is a parameter; types come from tpst_pkg.
interface tpst_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

### src/two_point_similarity_transform_core.sv
// Two-point similarity transform core: register stages from input transfer
// to result on the output register are 3 front, 5 numerator, 32 divider, 1 out.
// Throughput one item per cycle; the pipeline holds as a whole while a result
// waits. Items with an all-zero point pair make no result.
// rst_ni clears all valid bits asynchronously; payload registers are not reset.
// Depends on tpst_pkg, tpst_stream_if, tpst_front, tpst_numer and tpst_div.
module two_point_similarity_transform_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  tpst_stream_if.sink   in_i,
  tpst_stream_if.source out_o
);

  logic                  en;
  logic                  drop;
  logic                  fr_valid, dv_valid, q_valid;
  tpst_pkg::fr_t         fr;
  tpst_pkg::dv_t         dv;
  tpst_pkg::dvf_t        fl;
  logic [tpst_pkg::LANES-1:0][tpst_pkg::Q_W-1:0] q;
  tpst_pkg::out_item_t   res_d, res_q;
  logic                  out_valid_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  assign drop = (in_i.data.src1_x == '0 && in_i.data.src1_y == '0 &&
                 in_i.data.src2_x == '0 && in_i.data.src2_y == '0) ||
                (in_i.data.dst1_x == '0 && in_i.data.dst1_y == '0 &&
                 in_i.data.dst2_x == '0 && in_i.data.dst2_y == '0);

  tpst_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_i.valid && !drop),
    .item_i  (in_i.data),
    .valid_o (fr_valid),
    .fr_o    (fr)
  );

  tpst_numer #(.FRAC_BITS(FRAC_BITS)) u_numer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .fr_i    (fr),
    .valid_o (dv_valid),
    .dv_o    (dv)
  );

  tpst_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_valid),
    .dv_i    (dv),
    .valid_o (q_valid),
    .q_o     (q),
    .fl_o    (fl)
  );

  function automatic logic signed [31:0] finish(logic [tpst_pkg::Q_W-1:0] mag,
                                                logic neg, logic sat);
    if (sat) begin
      return neg ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  always_comb begin
    res_d.coef_a  = finish(q[tpst_pkg::LANE_A], fl.neg[tpst_pkg::LANE_A],
                           fl.sat[tpst_pkg::LANE_A]);
    res_d.coef_b  = finish(q[tpst_pkg::LANE_B], fl.neg[tpst_pkg::LANE_B],
                           fl.sat[tpst_pkg::LANE_B]);
    res_d.coef_c  = finish(q[tpst_pkg::LANE_B], fl.neg_c, fl.sat_c);
    res_d.coef_d  = res_d.coef_a;
    res_d.shift_x = finish(q[tpst_pkg::LANE_X], fl.neg[tpst_pkg::LANE_X],
                           fl.sat[tpst_pkg::LANE_X]);
    res_d.shift_y = finish(q[tpst_pkg::LANE_Y], fl.neg[tpst_pkg::LANE_Y],
                           fl.sat[tpst_pkg::LANE_Y]);
    res_d.status  = ((|fl.sat) || fl.sat_c) ? tpst_pkg::STATUS_SAT
                                            : tpst_pkg::STATUS_OK;
    // zero-length source segment: zero every field, status reports DEGEN
    if (fl.degen) begin
      res_d         = '0;
      res_d.status  = tpst_pkg::STATUS_DEGEN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= q_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = res_q;

endmodule

### src/tpst_front.sv
// Front end: segment vectors, six 33x33 products, den/dot/cross sums.
// Three register stages; uses tpst_pkg types.
module tpst_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  tpst_pkg::in_item_t item_i,
  output logic              valid_o,
  output tpst_pkg::fr_t     fr_o
);

  logic [2:0] vld_q;

  logic signed [32:0] a1_q, b1_q, a2_q, b2_q, y1_q, y1b_q;
  logic signed [31:0] x1_q, u1_q, v1_q, x1b_q, u1b_q, v1b_q;
  logic signed [65:0] aa_q, bb_q, ad_q, bd_q, ac_q, bc_q;
  tpst_pkg::fr_t      fr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // source y is negated, so b1 = s1y - s2y
      a1_q  <= 33'(item_i.src2_x) - 33'(item_i.src1_x);
      b1_q  <= 33'(item_i.src1_y) - 33'(item_i.src2_y);
      a2_q  <= 33'(item_i.dst2_x) - 33'(item_i.dst1_x);
      b2_q  <= 33'(item_i.dst2_y) - 33'(item_i.dst1_y);
      x1_q  <= item_i.src1_x;
      y1_q  <= -(33'(item_i.src1_y));
      u1_q  <= item_i.dst1_x;
      v1_q  <= item_i.dst1_y;

      aa_q  <= a1_q * a1_q;
      bb_q  <= b1_q * b1_q;
      ad_q  <= a1_q * a2_q;
      bd_q  <= b1_q * b2_q;
      ac_q  <= a1_q * b2_q;
      bc_q  <= b1_q * a2_q;
      x1b_q <= x1_q;
      y1b_q <= y1_q;
      u1b_q <= u1_q;
      v1b_q <= v1_q;

      fr_q.den <= tpst_pkg::DEN_W'(67'(aa_q) + 67'(bb_q));
      fr_q.dot <= 67'(ad_q) + 67'(bd_q);
      fr_q.crs <= 67'(ac_q) - 67'(bc_q);
      fr_q.x1  <= x1b_q;
      fr_q.y1  <= y1b_q;
      fr_q.u1  <= u1b_q;
      fr_q.v1  <= v1b_q;
    end
  end

  assign valid_o = vld_q[2];
  assign fr_o    = fr_q;

endmodule

### src/tpst_numer.sv
// Numerator build: split partial products, full products, numerators,
// rounded magnitudes and saturation checks. Five register stages; tpst_pkg.
module tpst_numer #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  tpst_pkg::fr_t fr_i,
  output logic          valid_o,
  output tpst_pkg::dv_t dv_o
);

  localparam int unsigned NW = tpst_pkg::NUM_W;
  localparam int unsigned SPLIT = 33;

  logic [4:0] vld_q;

  // split operands: low part unsigned, high part signed
  logic signed [33:0] den_l, den_h, dot_l, dot_h, crs_l, crs_h;
  assign den_l = {1'b0, fr_i.den[SPLIT-1:0]};
  assign den_h = {1'b0, fr_i.den[tpst_pkg::DEN_W-1:SPLIT]};
  assign dot_l = {1'b0, fr_i.dot[SPLIT-1:0]};
  assign dot_h = fr_i.dot[tpst_pkg::PRD_W-1:SPLIT];
  assign crs_l = {1'b0, fr_i.crs[SPLIT-1:0]};
  assign crs_h = fr_i.crs[tpst_pkg::PRD_W-1:SPLIT];

  logic signed [67:0] pul_q, puh_q, pvl_q, pvh_q, pdxl_q, pdxh_q;
  logic signed [67:0] pcyl_q, pcyh_q, pcxl_q, pcxh_q, pdyl_q, pdyh_q;
  logic [tpst_pkg::DEN_W-1:0]        den4_q, den5_q, den6_q, den7_q;
  logic signed [tpst_pkg::PRD_W-1:0] dot4_q, crs4_q, dot5_q, crs5_q;
  logic signed [NW-1:0] tud_q, tvd_q, tdx_q, tcy_q, tcx_q, tdy_q;
  logic signed [NW-1:0] na_q, nb_q, nx_q, ny_q;
  logic [tpst_pkg::LANES-1:0][tpst_pkg::MAG_W-1:0] mag_q;
  logic [tpst_pkg::LANES-1:0] neg_q;
  logic                       negc_q;
  tpst_pkg::dv_t              dv_q;

  function automatic logic signed [NW-1:0] join_pp(logic signed [67:0] h,
                                                   logic signed [67:0] l);
    return (NW'(h) <<< SPLIT) + NW'(l);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pul_q  <= 68'(fr_i.u1 * den_l);
      puh_q  <= 68'(fr_i.u1 * den_h);
      pvl_q  <= 68'(fr_i.v1 * den_l);
      pvh_q  <= 68'(fr_i.v1 * den_h);
      pdxl_q <= 68'(dot_l * fr_i.x1);
      pdxh_q <= 68'(dot_h * fr_i.x1);
      pcyl_q <= 68'(crs_l * fr_i.y1);
      pcyh_q <= 68'(crs_h * fr_i.y1);
      pcxl_q <= 68'(crs_l * fr_i.x1);
      pcxh_q <= 68'(crs_h * fr_i.x1);
      pdyl_q <= 68'(dot_l * fr_i.y1);
      pdyh_q <= 68'(dot_h * fr_i.y1);
      den4_q <= fr_i.den;
      dot4_q <= fr_i.dot;
      crs4_q <= fr_i.crs;

      tud_q  <= join_pp(puh_q, pul_q);
      tvd_q  <= join_pp(pvh_q, pvl_q);
      tdx_q  <= join_pp(pdxh_q, pdxl_q);
      tcy_q  <= join_pp(pcyh_q, pcyl_q);
      tcx_q  <= join_pp(pcxh_q, pcxl_q);
      tdy_q  <= join_pp(pdyh_q, pdyl_q);
      den5_q <= den4_q;
      dot5_q <= dot4_q;
      crs5_q <= crs4_q;

      na_q   <= NW'(dot5_q) <<< FRAC_BITS;
      nb_q   <= NW'(crs5_q) <<< FRAC_BITS;
      nx_q   <= tud_q - tdx_q + tcy_q;
      ny_q   <= tvd_q - tcx_q - tdy_q;
      den6_q <= den5_q;

      mag_q[tpst_pkg::LANE_A] <= tpst_pkg::mag_round(na_q, den6_q);
      mag_q[tpst_pkg::LANE_B] <= tpst_pkg::mag_round(nb_q, den6_q);
      mag_q[tpst_pkg::LANE_X] <= tpst_pkg::mag_round(nx_q, den6_q);
      mag_q[tpst_pkg::LANE_Y] <= tpst_pkg::mag_round(ny_q, den6_q);
      neg_q  <= {ny_q[NW-1], nx_q[NW-1], nb_q[NW-1], na_q[NW-1]};
      // m21 numerator is the negated m12 numerator
      negc_q <= (nb_q != '0) && !nb_q[NW-1];
      den7_q <= den6_q;

      dv_q.mag      <= mag_q;
      dv_q.fl.den   <= den7_q;
      dv_q.fl.neg   <= neg_q;
      for (int l = 0; l < tpst_pkg::LANES; l++) begin
        dv_q.fl.sat[l] <= tpst_pkg::over(mag_q[l], den7_q, neg_q[l]);
      end
      dv_q.fl.neg_c <= negc_q;
      dv_q.fl.sat_c <= tpst_pkg::over(mag_q[tpst_pkg::LANE_B], den7_q, negc_q);
      dv_q.fl.degen <= (den7_q == '0);
    end
  end

  assign valid_o = vld_q[4];
  assign dv_o    = dv_q;

endmodule

### src/tpst_div.sv
// Four-lane restoring divider, one quotient bit per register stage.
// 32 stages; quotient valid when the magnitude is below den*2^32. tpst_pkg.
module tpst_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  tpst_pkg::dv_t                         dv_i,
  output logic                                  valid_o,
  output logic [tpst_pkg::LANES-1:0][tpst_pkg::Q_W-1:0] q_o,
  output tpst_pkg::dvf_t                        fl_o
);

  localparam int unsigned STG = tpst_pkg::Q_W;
  localparam int unsigned MW  = tpst_pkg::MAG_W;

  logic [STG-1:0] vld_q;
  logic [tpst_pkg::LANES-1:0][MW-1:0]               rem_in [STG];
  logic [tpst_pkg::LANES-1:0][MW-1:0]               rem_q  [STG];
  logic [tpst_pkg::LANES-1:0][tpst_pkg::Q_W-1:0]    q_in   [STG];
  logic [tpst_pkg::LANES-1:0][tpst_pkg::Q_W-1:0]    q_q    [STG];
  tpst_pkg::dvf_t                                   fl_in  [STG];
  tpst_pkg::dvf_t                                   fl_q   [STG];

  assign rem_in[0] = dv_i.mag;
  assign q_in[0]   = '0;
  assign fl_in[0]  = dv_i.fl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[STG-2:0], valid_i};
    end
  end

  for (genvar s = 0; s < STG; s++) begin : g_stage
    logic [MW-1:0] dsh;
    assign dsh = MW'(fl_in[s].den) << (STG - 1 - s);

    if (s > 0) begin : g_link
      assign rem_in[s] = rem_q[s-1];
      assign q_in[s]   = q_q[s-1];
      assign fl_in[s]  = fl_q[s-1];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        fl_q[s] <= fl_in[s];
        for (int l = 0; l < tpst_pkg::LANES; l++) begin
          // subtract the shifted divisor when it fits, set this quotient bit
          if (rem_in[s][l] >= dsh) begin
            rem_q[s][l] <= rem_in[s][l] - dsh;
            q_q[s][l]   <= q_in[s][l] | (tpst_pkg::Q_W'(1) << (STG - 1 - s));
          end else begin
            rem_q[s][l] <= rem_in[s][l];
            q_q[s][l]   <= q_in[s][l];
          end
        end
      end
    end
  end

  assign valid_o = vld_q[STG-1];
  assign q_o     = q_q[STG-1];
  assign fl_o    = fl_q[STG-1];

endmodule
